// ----- rtl/assert_macros.svh -----
// ============================================================================
// Assertion macros
// Clocked assertion wrappers shared by the console editor RTL.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold in the same cycle
`define TCLE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define TCLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/tcle_pkg.sv -----
// ============================================================================
// tcle_pkg
// Types and fixed constants for the text console line editor.
// ============================================================================
`default_nettype none

package tcle_pkg;

    // Request selector on the input stream
    typedef enum logic [1:0] {
        REQ_KEY     = 2'd0,
        REQ_PRINT   = 2'd1,
        REQ_NEWLINE = 2'd2,
        REQ_CLEAR   = 2'd3
    } t_req;

    // Result kind on the output stream
    typedef enum logic [1:0] {
        KIND_CELL = 2'd0,
        KIND_LINE = 2'd1,
        KIND_FILL = 2'd2
    } t_kind;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REPLAY,
        ST_TERM
    } t_state;

    // Cursor update commands
    typedef enum logic [2:0] {
        CUR_HOLD,
        CUR_ADVANCE,
        CUR_BACK,
        CUR_NEWLINE,
        CUR_HOME
    } t_cur_op;

    localparam int          CELL_W        = 11;
    localparam int          CHAR_W        = 8;
    localparam int          STORE_W       = 7;
    localparam logic [7:0]  KEY_ENTER     = 8'd13;
    localparam logic [7:0]  KEY_BACKSPACE = 8'd8;
    localparam logic [7:0]  KEY_PRINT_LO  = 8'd32;
    localparam logic [7:0]  KEY_PRINT_HI  = 8'd126;
    localparam logic [7:0]  CHAR_SPACE    = 8'd32;
    localparam logic [7:0]  CHAR_NUL      = 8'd0;
    localparam logic [7:0]  FILL_ATTR     = 8'h07;
    localparam logic [7:0]  ATTR_RESET    = 8'h07;
    localparam logic [7:0]  ATTR_NONE     = 8'h00;

endpackage

`default_nettype wire

// ----- rtl/tcle_ram.sv -----
// ============================================================================
// tcle_ram
// Generic single-write, single-read RAM with registered, enabled read.
// ============================================================================
`default_nettype none

module tcle_ram #(
    parameter  int WIDTH  = 8,
    parameter  int DEPTH  = 64,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output      logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/tcle_cursor.sv -----
// ============================================================================
// tcle_cursor
// Cursor position with a companion column counter, so the newline jump needs
// no division: advance, step back, next row, home.
// ============================================================================
`default_nettype none

module tcle_cursor
    import tcle_pkg::*;
#(
    parameter  int SCREEN_COLS = 80,
    parameter  int SCREEN_ROWS = 25,
    localparam int TOTAL       = SCREEN_COLS * SCREEN_ROWS,
    localparam int CUR_W       = $clog2(TOTAL)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cur_op          i_op,
    output      logic [CUR_W-1:0] o_cur,
    output      logic [CUR_W-1:0] o_cur_prev
);

    localparam int COL_W = $clog2(SCREEN_COLS);

    logic [CUR_W-1:0] r_cur, n_cur;
    logic [COL_W-1:0] r_col, n_col;
    logic [CUR_W-1:0] prev_cur;
    logic [COL_W-1:0] prev_col;
    logic [CUR_W:0]   row_next;

    // one cell back, wrapping from the first cell to the last
    always_comb begin
        if (r_cur == '0) begin
            prev_cur = CUR_W'(TOTAL - 1);
            prev_col = COL_W'(SCREEN_COLS - 1);
        end else begin
            prev_cur = r_cur - CUR_W'(1);
            prev_col = (r_col == '0) ? COL_W'(SCREEN_COLS - 1) : r_col - COL_W'(1);
        end
    end

    // start of the following row
    assign row_next = {1'b0, r_cur} - (CUR_W + 1)'(r_col) + (CUR_W + 1)'(SCREEN_COLS);

    // next cursor
    always_comb begin
        n_cur = r_cur;
        n_col = r_col;
        case (i_op)
            CUR_ADVANCE: begin
                if (r_cur == CUR_W'(TOTAL - 1)) begin
                    n_cur = '0;
                    n_col = '0;
                end else begin
                    n_cur = r_cur + CUR_W'(1);
                    n_col = (r_col == COL_W'(SCREEN_COLS - 1)) ? '0 : r_col + COL_W'(1);
                end
            end
            CUR_BACK: begin
                n_cur = prev_cur;
                n_col = prev_col;
            end
            CUR_NEWLINE: begin
                n_cur = (row_next >= (CUR_W + 1)'(TOTAL)) ? '0 : row_next[CUR_W-1:0];
                n_col = '0;
            end
            CUR_HOME: begin
                n_cur = '0;
                n_col = '0;
            end
            default: begin
                n_cur = r_cur;
                n_col = r_col;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur <= '0;
            r_col <= '0;
        end else begin
            r_cur <= n_cur;
            r_col <= n_col;
        end
    end

    assign o_cur      = r_cur;
    assign o_cur_prev = prev_cur;

endmodule

`default_nettype wire

// ----- rtl/text_console_line_editor.sv -----
// ============================================================================
// text_console_line_editor
// Console request handler: screen cursor, line edit buffer in RAM, and a
// registered result stream of cell writes, line characters and screen fills.
// ============================================================================
//  channel   direction  transaction carries
//  s_axis    in         tuser = req_type, tdata = char_code
//  m_axis    out        tuser = result_kind, tdata = cell/char/attr, tlast
//  cfg       in         text_attribute byte
//
//  Print, newline, clear and edit keys are accepted back to back while
//  the result register drains. Enter with buffered characters keeps the
//  input stalled through the terminator: the accepting cycle issues the
//  first line store read, then one result per cycle off the RAM read port
//  while the output is not stalled, then the terminator.
//  Reset is synchronous; no clearing pass, the line store is only read
//  below the line length. A stalled output stops input acceptance.
// ============================================================================
`default_nettype none

module text_console_line_editor
    import tcle_pkg::*;
#(
    parameter int SCREEN_COLS   = 80,
    parameter int SCREEN_ROWS   = 25,
    parameter int LINE_CAPACITY = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write
    input  wire logic        i_cfg_valid,
    output      logic        o_cfg_ready,
    input  wire logic [7:0]  i_cfg_data,
    // request stream
    input  wire logic        i_s_axis_tvalid,
    output      logic        o_s_axis_tready,
    input  wire logic [1:0]  i_s_axis_tuser,   // [1:0] req_type
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] char_code
    // result stream
    output      logic        o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output      logic [1:0]  o_m_axis_tuser,   // [1:0] result_kind
    output      logic [31:0] o_m_axis_tdata,   // [10:0] cell_index, [18:11] cell_char,
                                               // [26:19] cell_attr, [31:27] zero
    output      logic        o_m_axis_tlast    // last_of_run
);

    localparam int CUR_W = $clog2(SCREEN_COLS * SCREEN_ROWS);
    localparam int LEN_W = $clog2(LINE_CAPACITY);

    // ------------------------------------------------------------------
    // state
    t_state             r_state, n_state;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [LEN_W-1:0]   r_idx, n_idx;
    logic [7:0]         r_attr;

    logic               r_out_valid;
    t_kind              r_out_kind;
    logic [CELL_W-1:0]  r_out_cell;
    logic [7:0]         r_out_char;
    logic [7:0]         r_out_attr;
    logic               r_out_last;

    // combinational controls
    logic               slot_free;
    logic               accept;
    logic               load;
    t_kind              ld_kind;
    logic [CELL_W-1:0]  ld_cell;
    logic [7:0]         ld_char;
    logic [7:0]         ld_attr;
    logic               ld_last;
    t_cur_op            cur_op;
    logic               ram_we, ram_re;
    logic [LEN_W-1:0]   ram_waddr, ram_raddr;
    logic [STORE_W-1:0] ram_rdata;
    logic [CUR_W-1:0]   cur, cur_prev;
    t_req               req;
    logic [7:0]         key;
    logic               printable;

    // ------------------------------------------------------------------
    // line store and cursor
    tcle_ram #(
        .WIDTH (STORE_W),
        .DEPTH (LINE_CAPACITY)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (key[STORE_W-1:0]),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    tcle_cursor #(
        .SCREEN_COLS (SCREEN_COLS),
        .SCREEN_ROWS (SCREEN_ROWS)
    ) u_cursor (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (cur_op),
        .o_cur      (cur),
        .o_cur_prev (cur_prev)
    );

    // ------------------------------------------------------------------
    // configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= ATTR_RESET;
        end else if (i_cfg_valid) begin
            r_attr <= i_cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // controller: next state, line length, RAM and result load
    assign slot_free = !r_out_valid || i_m_axis_tready;
    assign req       = t_req'(i_s_axis_tuser);
    assign key       = i_s_axis_tdata;
    assign printable = (key >= KEY_PRINT_LO) && (key <= KEY_PRINT_HI);
    assign accept    = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        n_state         = r_state;
        n_len           = r_len;
        n_idx           = r_idx;
        o_s_axis_tready = 1'b0;
        load            = 1'b0;
        ld_kind         = KIND_CELL;
        ld_cell         = CELL_W'(cur);
        ld_char         = key;
        ld_attr         = r_attr;
        ld_last         = 1'b1;
        cur_op          = CUR_HOLD;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_waddr       = r_len;
        ram_raddr       = '0;
        case (r_state)
            ST_IDLE: begin
                o_s_axis_tready = slot_free;
                if (accept) begin
                    case (req)
                        REQ_KEY: begin
                            if (key == KEY_ENTER) begin
                                if (r_len == '0) begin
                                    load    = 1'b1;
                                    ld_kind = KIND_LINE;
                                    ld_cell = '0;
                                    ld_char = CHAR_NUL;
                                    ld_attr = ATTR_NONE;
                                end else begin
                                    ram_re  = 1'b1;
                                    n_idx   = '0;
                                    n_state = ST_REPLAY;
                                end
                            end else if (key == KEY_BACKSPACE) begin
                                if (r_len != '0) begin
                                    n_len   = r_len - LEN_W'(1);
                                    cur_op  = CUR_BACK;
                                    load    = 1'b1;
                                    ld_cell = CELL_W'(cur_prev);
                                    ld_char = CHAR_SPACE;
                                end
                            end else if (printable && r_len != LEN_W'(LINE_CAPACITY - 1)) begin
                                ram_we = 1'b1;
                                n_len  = r_len + LEN_W'(1);
                                cur_op = CUR_ADVANCE;
                                load   = 1'b1;
                            end
                        end
                        REQ_PRINT: begin
                            cur_op = CUR_ADVANCE;
                            load   = 1'b1;
                        end
                        REQ_NEWLINE: begin
                            cur_op = CUR_NEWLINE;
                        end
                        REQ_CLEAR: begin
                            cur_op  = CUR_HOME;
                            load    = 1'b1;
                            ld_kind = KIND_FILL;
                            ld_cell = '0;
                            ld_char = CHAR_SPACE;
                            ld_attr = FILL_ATTR;
                        end
                        default: begin
                            cur_op = CUR_HOLD;
                        end
                    endcase
                end
            end
            ST_REPLAY: begin
                // read data for r_idx sits on the RAM port
                if (slot_free) begin
                    load    = 1'b1;
                    ld_kind = KIND_LINE;
                    ld_cell = '0;
                    ld_char = {1'b0, ram_rdata};
                    ld_attr = ATTR_NONE;
                    ld_last = 1'b0;
                    if (r_idx == r_len - LEN_W'(1)) begin
                        n_state = ST_TERM;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = r_idx + LEN_W'(1);
                        n_idx     = r_idx + LEN_W'(1);
                    end
                end
            end
            ST_TERM: begin
                if (slot_free) begin
                    load    = 1'b1;
                    ld_kind = KIND_LINE;
                    ld_cell = '0;
                    ld_char = CHAR_NUL;
                    ld_attr = ATTR_NONE;
                    n_len   = '0;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_len   <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_idx   <= n_idx;
        end
    end

    // ------------------------------------------------------------------
    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_kind <= ld_kind;
            r_out_cell <= ld_cell;
            r_out_char <= ld_char;
            r_out_attr <= ld_attr;
            r_out_last <= ld_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_kind;
    assign o_m_axis_tdata  = {5'd0, r_out_attr, r_out_char, r_out_cell};
    assign o_m_axis_tlast  = r_out_last;

    // ------------------------------------------------------------------
    // assertions
    `include "assert_macros.svh"

    `TCLE_ASSERT(a_busy_no_accept, (r_state == ST_IDLE) || !o_s_axis_tready, "input ready during replay")
    `TCLE_ASSERT(a_ram_one_port, !(ram_we && ram_re), "line store read and written together")
    `TCLE_ASSERT_NEXT(a_term_clears, (r_state == ST_TERM) && slot_free, (r_len == '0) && (r_state == ST_IDLE) && r_out_valid && r_out_last, "terminator did not empty the line")

endmodule

`default_nettype wire
